>>> rtl/assert_macros.svh
// Assertion macros for the RTL of the primaries-to-XYZ block.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define PXM_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pxm assertion failed");

// Antecedent in this cycle implies consequent in the next one.
`define PXM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pxm assertion failed");

`endif

>>> rtl/pxm_pkg.sv
// Package for the primaries-to-XYZ matrix block: widths, word types, helpers.
// No dependencies.
package pxm_pkg;

   localparam int IN_W          = 16;
   localparam int OUT_W         = 20;
   localparam int FRAC_BITS_DEF = 16;
   localparam int INT_BITS      = 21;   // quotient integer bits before clamping
   localparam int DIFF_W        = 17;
   localparam int PROD_W        = 34;
   localparam int WGT_W         = 35;
   localparam int COL_W         = 18;
   localparam int NUM_W         = 53;
   localparam int MAG_W         = 52;
   localparam int LANES         = 9;

   localparam logic signed [OUT_W-1:0] OUT_MAX = 20'sd524287;
   localparam logic signed [OUT_W-1:0] OUT_MIN = -20'sd524288;
   localparam logic signed [COL_W-1:0] ONE_Q16 = 18'sd65536;

   typedef struct packed {
      logic [IN_W-1:0] red_x;
      logic [IN_W-1:0] red_y;
      logic [IN_W-1:0] green_x;
      logic [IN_W-1:0] green_y;
      logic [IN_W-1:0] blue_x;
      logic [IN_W-1:0] blue_y;
      logic [IN_W-1:0] white_x;
      logic [IN_W-1:0] white_y;
   } req_type;

   typedef struct packed {
      logic signed [OUT_W-1:0] x_from_red;
      logic signed [OUT_W-1:0] x_from_green;
      logic signed [OUT_W-1:0] x_from_blue;
      logic signed [OUT_W-1:0] y_from_red;
      logic signed [OUT_W-1:0] y_from_green;
      logic signed [OUT_W-1:0] y_from_blue;
      logic signed [OUT_W-1:0] z_from_red;
      logic signed [OUT_W-1:0] z_from_green;
      logic signed [OUT_W-1:0] z_from_blue;
      logic                    degenerate;
      logic                    saturated;
   } rsp_type;

   // Operands of the nine divisions, lane = row*3 + column.
   typedef struct packed {
      logic                          degen;
      logic [MAG_W-1:0]              den_mag;
      logic [LANES-1:0]              neg;
      logic [LANES-1:0][MAG_W-1:0]   num_mag;
   } div_in_type;

   function automatic logic signed [DIFF_W-1:0] diff(input logic [IN_W-1:0] a,
                                                     input logic [IN_W-1:0] b);
      diff = $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   function automatic logic signed [COL_W-1:0] zcol(input logic [IN_W-1:0] x,
                                                    input logic [IN_W-1:0] y);
      zcol = ONE_Q16 - $signed({2'b00, x}) - $signed({2'b00, y});
   endfunction

endpackage

>>> rtl/pxm_req_if.sv
// Input channel interface: valid/ready with a set of chromaticities.
// Depends on pxm_pkg.
interface pxm_req_if;
   logic             valid;
   logic             ready;
   pxm_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/pxm_rsp_if.sv
// Result channel interface: valid/ready with the nine matrix entries and flags.
// Depends on pxm_pkg.
interface pxm_rsp_if;
   logic             valid;
   logic             ready;
   pxm_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> rtl/pxm_setup.sv
// Front pipeline: differences, D/E/F, numerators and denominator, magnitudes.
// Five register stages. Depends on pxm_pkg.
module pxm_setup (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pxm_pkg::req_type     in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pxm_pkg::div_in_type  out_data
);
   import pxm_pkg::*;

   logic [4:0] v_ff;
   logic [5:0] rdy;
   logic [4:0] vprev;

   logic signed [PROD_W-1:0] prod_ff [6];
   logic signed [COL_W-1:0]  col1_ff [LANES];
   logic signed [WGT_W-1:0]  wgt_ff [3];     // F, D, E
   logic signed [COL_W-1:0]  col2_ff [LANES];
   logic signed [NUM_W-1:0]  pden_ff [3];
   logic signed [NUM_W-1:0]  num3_ff [LANES];
   logic                     f0_3_ff;
   logic signed [NUM_W-1:0]  den4_ff;
   logic signed [NUM_W-1:0]  num4_ff [LANES];
   logic                     f0_4_ff;
   div_in_type               out_ff;

   logic signed [DIFF_W-1:0] d_rw, d_wb, d_wbx, d_rwy, d_wgx, d_wgy;

   always_comb begin
      rdy[5] = out_ready;
      for (int k = 0; k < 5; k++) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end
   assign vprev    = {v_ff[3:0], in_valid};
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < 5; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= vprev[k];
            end
         end
      end
   end

   assign d_rw  = diff(in_data.red_x, in_data.white_x);
   assign d_wb  = diff(in_data.white_y, in_data.blue_y);
   assign d_wbx = diff(in_data.white_x, in_data.blue_x);
   assign d_rwy = diff(in_data.red_y, in_data.white_y);
   assign d_wgx = diff(in_data.white_x, in_data.green_x);
   assign d_wgy = diff(in_data.white_y, in_data.green_y);

   // stage 1: the six cross products and the primary columns
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         prod_ff[0] <= d_rw * d_wb;
         prod_ff[1] <= d_wbx * d_rwy;
         prod_ff[2] <= d_wgx * d_rwy;
         prod_ff[3] <= d_rw * d_wgy;
         prod_ff[4] <= d_wgx * d_wb;
         prod_ff[5] <= d_wbx * d_wgy;
         col1_ff[0] <= $signed({2'b00, in_data.red_x});
         col1_ff[1] <= $signed({2'b00, in_data.green_x});
         col1_ff[2] <= $signed({2'b00, in_data.blue_x});
         col1_ff[3] <= $signed({2'b00, in_data.red_y});
         col1_ff[4] <= $signed({2'b00, in_data.green_y});
         col1_ff[5] <= $signed({2'b00, in_data.blue_y});
         col1_ff[6] <= zcol(in_data.red_x, in_data.red_y);
         col1_ff[7] <= zcol(in_data.green_x, in_data.green_y);
         col1_ff[8] <= zcol(in_data.blue_x, in_data.blue_y);
      end
   end

   // stage 2: column weights
   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         wgt_ff[0] <= WGT_W'(prod_ff[4]) - WGT_W'(prod_ff[5]);
         wgt_ff[1] <= WGT_W'(prod_ff[0]) - WGT_W'(prod_ff[1]);
         wgt_ff[2] <= WGT_W'(prod_ff[2]) - WGT_W'(prod_ff[3]);
         col2_ff   <= col1_ff;
      end
   end

   // stage 3: numerators and the terms of P*F
   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         for (int l = 0; l < LANES; l++) begin
            num3_ff[l] <= col2_ff[l] * wgt_ff[l % 3];
         end
         for (int c = 0; c < 3; c++) begin
            pden_ff[c] <= col2_ff[3 + c] * wgt_ff[c];
         end
         f0_3_ff <= (wgt_ff[0] == '0);
      end
   end

   // stage 4: denominator sum
   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         den4_ff <= pden_ff[0] + pden_ff[1] + pden_ff[2];
         num4_ff <= num3_ff;
         f0_4_ff <= f0_3_ff;
      end
   end

   // stage 5: signs and magnitudes
   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         out_ff.degen   <= f0_4_ff || (den4_ff == '0);
         out_ff.den_mag <= den4_ff[NUM_W-1] ? MAG_W'(-den4_ff) : MAG_W'(den4_ff);
         for (int l = 0; l < LANES; l++) begin
            out_ff.neg[l]     <= num4_ff[l][NUM_W-1] ^ den4_ff[NUM_W-1];
            out_ff.num_mag[l] <= num4_ff[l][NUM_W-1] ? MAG_W'(-num4_ff[l])
                                                     : MAG_W'(num4_ff[l]);
         end
      end
   end

   assign out_valid = v_ff[4];
   assign out_data  = out_ff;

endmodule

>>> rtl/pxm_div.sv
// Nine-lane pipelined restoring divider, one quotient bit per stage, with
// rounding, clamping and the result word register. Depends on pxm_pkg.
`include "assert_macros.svh"
module pxm_div #(
   parameter int FRAC_BITS = pxm_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  pxm_pkg::div_in_type  in_data,
   output logic                 out_valid,
   input  logic                 out_ready,
   output pxm_pkg::rsp_type     out_data
);
   import pxm_pkg::*;

   localparam int QW  = INT_BITS + FRAC_BITS + 1;
   localparam int NST = QW + 2;

   logic [NST-1:0] v_ff;
   logic [NST:0]   rdy;
   logic [NST-1:0] vprev;

   logic [LANES-1:0][MAG_W-1:0] rem_ff [QW+1];
   logic [LANES-1:0][QW-1:0]    ql_ff [QW+1];
   logic [LANES-1:0]            ovf_ff [QW+1];
   logic [LANES-1:0]            neg_ff [QW+1];
   logic [MAG_W-1:0]            den_ff [QW+1];
   logic                        dgn_ff [QW+1];

   rsp_type                     out_ff;
   rsp_type                     out_in;
   logic signed [OUT_W-1:0]     ent [LANES];
   logic [LANES-1:0]            clamp;
   logic                        any_rail;

   always_comb begin
      rdy[NST] = out_ready;
      for (int k = 0; k < NST; k++) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end
   assign vprev    = {v_ff[NST-2:0], in_valid};
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < NST; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= vprev[k];
            end
         end
      end
   end

   // first stage: integer part overflow check and starting remainder
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         for (int l = 0; l < LANES; l++) begin
            rem_ff[0][l] <= in_data.num_mag[l] >> INT_BITS;
            ql_ff[0][l]  <= {in_data.num_mag[l][INT_BITS-1:0], {(FRAC_BITS+1){1'b0}}};
            ovf_ff[0][l] <= (in_data.num_mag[l] >> INT_BITS) >= in_data.den_mag;
         end
         neg_ff[0] <= in_data.neg;
         den_ff[0] <= in_data.den_mag;
         dgn_ff[0] <= in_data.degen;
      end
   end

   // one quotient bit per stage; dividend bits shift out the top of ql,
   // quotient bits shift in at the bottom
   for (genvar s = 1; s <= QW; s++) begin : g_step
      logic [LANES-1:0][MAG_W:0] trial;
      logic [LANES-1:0]          ge;

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            trial[l] = {rem_ff[s-1][l], ql_ff[s-1][l][QW-1]};
            ge[l]    = trial[l] >= {1'b0, den_ff[s-1]};
         end
      end

      always_ff @(posedge clock) begin
         if (rdy[s]) begin
            for (int l = 0; l < LANES; l++) begin
               rem_ff[s][l] <= ge[l] ? MAG_W'(trial[l] - {1'b0, den_ff[s-1]})
                                     : trial[l][MAG_W-1:0];
               ql_ff[s][l]  <= {ql_ff[s-1][l][QW-2:0], ge[l]};
            end
            ovf_ff[s] <= ovf_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            den_ff[s] <= den_ff[s-1];
            dgn_ff[s] <= dgn_ff[s-1];
         end
      end
   end

   // round half away from zero, clamp to the 20-bit range; zeros if degenerate
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         logic [QW:0]   sum;
         logic [QW-1:0] mag;
         sum = {1'b0, ql_ff[QW][l]} + 1'b1;
         mag = sum[QW:1];
         if (dgn_ff[QW]) begin
            ent[l]   = '0;
            clamp[l] = 1'b0;
         end else if (neg_ff[QW][l]) begin
            // most negative magnitude is the bit pattern of OUT_MIN read unsigned
            clamp[l] = ovf_ff[QW][l] || (mag > QW'($unsigned(OUT_MIN)));
            ent[l]   = clamp[l] ? OUT_MIN : -$signed(mag[OUT_W-1:0]);
         end else begin
            clamp[l] = ovf_ff[QW][l] || (mag > QW'(OUT_MAX));
            ent[l]   = clamp[l] ? OUT_MAX : $signed(mag[OUT_W-1:0]);
         end
      end
      out_in = {ent[0], ent[1], ent[2], ent[3], ent[4], ent[5], ent[6], ent[7], ent[8],
                dgn_ff[QW], |clamp};
   end

   always_ff @(posedge clock) begin
      if (rdy[NST-1]) begin
         out_ff <= out_in;
      end
   end

   assign out_valid = v_ff[NST-1];
   assign out_data  = out_ff;

   always_comb begin
      any_rail = 1'b0;
      for (int l = 0; l < LANES; l++) begin
         any_rail = any_rail || (ent[l] == OUT_MAX) || (ent[l] == OUT_MIN);
      end
   end

   `PXM_ASSERT(a_degen_clean, clock, reset, !(out_valid && out_data.degenerate) || (!out_data.saturated && out_data.x_from_red == '0 && out_data.y_from_green == '0 && out_data.z_from_blue == '0))
   `PXM_ASSERT(a_rem_below_den, clock, reset, !(v_ff[QW] && !dgn_ff[QW] && !ovf_ff[QW][0]) || (rem_ff[QW][0] < den_ff[QW]))
   `PXM_ASSERT(a_clamp_on_rail, clock, reset, !(v_ff[QW] && (|clamp)) || any_rail)
   `PXM_ASSERT_NEXT(a_entry_taken, clock, reset, in_valid && rdy[0], v_ff[0])

endmodule

>>> rtl/primaries_to_xyz_matrix.sv
// Primaries-to-XYZ matrix: chromaticities of R, G, B and white in, the
// 3x3 RGB-to-XYZ matrix out. Depends on pxm_pkg, pxm_req_if, pxm_rsp_if,
// pxm_setup and pxm_div.
//
// Usage:
//   req_ch carries one word of eight unsigned Q0.16 chromaticities; rsp_ch
//   returns one word of nine signed entries with FRAC_BITS fraction bits
//   plus the degenerate and saturated flags. Both are valid/ready channels.
//   The pipeline has five setup stages (products, weights, numerators,
//   denominator sum, magnitudes), one overflow stage, one restoring
//   divider stage per quotient bit, and the rounding/output register.
//   Throughput is one word per cycle unless stalled; separate words fly in
//   the pipeline at the same time. Each stage holds its word while the one
//   after it is full and stalled, so a stalled receiver fills the bubbles
//   first and then holds req_ch.ready low; nothing is dropped or repeated.
//   Synchronous reset empties the pipeline; no other state is kept.
module primaries_to_xyz_matrix #(
   parameter int FRAC_BITS = pxm_pkg::FRAC_BITS_DEF
) (
   input  logic     clock,
   input  logic     reset,
   pxm_req_if.sink  req_ch,
   pxm_rsp_if.source rsp_ch
);
   import pxm_pkg::*;

   logic       mid_valid;
   logic       mid_ready;
   div_in_type mid_data;

   pxm_setup u_setup (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .in_data   (req_ch.data),
      .out_valid (mid_valid),
      .out_ready (mid_ready),
      .out_data  (mid_data)
   );

   pxm_div #(
      .FRAC_BITS (FRAC_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mid_valid),
      .in_ready  (mid_ready),
      .in_data   (mid_data),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_ch.data)
   );

endmodule

>>> bench/primaries_to_xyz_matrix_test.sv
// Self-checking bench for primaries_to_xyz_matrix: directed table, then random
// chromaticity sets under four idle/stall phases. Depends on pxm_pkg, pxm_req_if, pxm_rsp_if.
module primaries_to_xyz_matrix_test;
   import pxm_pkg::*;

   localparam int DIR_ROWS   = 15;
   localparam int RAND_WORDS = 1435;
   localparam int DRAIN_CYC  = 60;

   logic clock;
   logic reset;
   pxm_req_if req_ch ();
   pxm_rsp_if rsp_ch ();

   primaries_to_xyz_matrix u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source)
   );

   rsp_type matrix_q[$];
   int      errors;
   int      send_idle_pct;
   int      recv_stall_pct;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One entry: num/den scaled by 2^16, rounded half away from zero, clamped.
   function automatic longint scaled_ratio(longint num, longint den, inout bit clamp);
      bit neg;
      longint unsigned n, d, q, rm, t, mag;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      if (n == 0) return 0;
      q = n / d;
      rm = n % d;
      if (q >= (64'd1 << INT_BITS)) begin
         clamp = 1'b1;
         return neg ? -524288 : 524287;
      end
      t = q;
      for (int i = 0; i < FRAC_BITS_DEF + 1; i++) begin
         rm = rm << 1;
         t = t << 1;
         if (rm >= d) begin
            rm = rm - d;
            t = t | 64'd1;
         end
      end
      mag = (t + 1) >> 1;
      if (neg) begin
         if (mag > 64'd524288) begin
            clamp = 1'b1;
            return -524288;
         end
         return -longint'(mag);
      end
      if (mag > 64'd524287) begin
         clamp = 1'b1;
         return 524287;
      end
      return longint'(mag);
   endfunction

   function automatic rsp_type predict_matrix(req_type r);
      longint rx, ry, gx, gy, bx, by, wx, wy, dd, ee, ff, den;
      longint cx[3], cy[3], cz[3], wgt[3], ent[9];
      bit clamp, degen;
      rsp_type m;
      rx = r.red_x;   ry = r.red_y;   gx = r.green_x; gy = r.green_y;
      bx = r.blue_x;  by = r.blue_y;  wx = r.white_x; wy = r.white_y;
      dd = (rx - wx) * (wy - by) - (wx - bx) * (ry - wy);
      ee = (wx - gx) * (ry - wy) - (rx - wx) * (wy - gy);
      ff = (wx - gx) * (wy - by) - (wx - bx) * (wy - gy);
      den = ry * ff + gy * dd + by * ee;
      cx = '{rx, gx, bx};
      cy = '{ry, gy, by};
      cz = '{65536 - rx - ry, 65536 - gx - gy, 65536 - bx - by};
      wgt = '{ff, dd, ee};
      clamp = 1'b0;
      degen = (ff == 0) || (den == 0);
      for (int c = 0; c < 3; c++) begin
         if (degen) begin
            ent[c] = 0; ent[3+c] = 0; ent[6+c] = 0;
         end else begin
            ent[c]   = scaled_ratio(cx[c] * wgt[c], den, clamp);
            ent[3+c] = scaled_ratio(cy[c] * wgt[c], den, clamp);
            ent[6+c] = scaled_ratio(cz[c] * wgt[c], den, clamp);
         end
      end
      m.x_from_red   = ent[0][OUT_W-1:0];
      m.x_from_green = ent[1][OUT_W-1:0];
      m.x_from_blue  = ent[2][OUT_W-1:0];
      m.y_from_red   = ent[3][OUT_W-1:0];
      m.y_from_green = ent[4][OUT_W-1:0];
      m.y_from_blue  = ent[5][OUT_W-1:0];
      m.z_from_red   = ent[6][OUT_W-1:0];
      m.z_from_green = ent[7][OUT_W-1:0];
      m.z_from_blue  = ent[8][OUT_W-1:0];
      m.degenerate   = degen;
      m.saturated    = clamp;
      return m;
   endfunction

   function automatic logic [IN_W-1:0] jitter(int base, int span);
      int v;
      v = base + $urandom_range(2 * span) - span;
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[IN_W-1:0];
   endfunction

   // Mostly plausible gamuts, some full-range noise, some white near a primary.
   function automatic req_type random_set();
      req_type r;
      int kind;
      kind = $urandom_range(99);
      if (kind < 55) begin
         r = '{jitter(43000, 6000), jitter(21000, 6000), jitter(18000, 6000),
               jitter(45000, 8000), jitter(9800, 4000), jitter(3900, 3900),
               jitter(20500, 3000), jitter(22000, 3000)};
      end else if (kind < 85) begin
         r = req_type'({$urandom, $urandom, $urandom, $urandom});
      end else begin
         r = req_type'({$urandom, $urandom, $urandom, $urandom});
         case ($urandom_range(2))
            0: begin r.white_x = jitter(r.red_x, 2); r.white_y = jitter(r.red_y, 2); end
            1: begin r.white_x = jitter(r.green_x, 2); r.white_y = jitter(r.green_y, 2); end
            default: begin r.white_x = jitter(r.blue_x, 2); r.white_y = jitter(r.blue_y, 2); end
         endcase
      end
      return r;
   endfunction

   task automatic send_word(req_type r, rsp_type m);
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      do @(posedge clock); while (!req_ch.ready);
      matrix_q.insert(matrix_q.size(), m);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   task automatic wait_empty();
      while (matrix_q.size() != 0) @(posedge clock);
   endtask

   // Directed sets: R, G, B, white x/y. Flagged rows have F or P zero by construction.
   logic [IN_W-1:0] dir_rows [DIR_ROWS][8] = '{
      '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
      '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
      '{16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000},
      '{16'd41943, 16'd21627, 16'd19661, 16'd39322, 16'd9830, 16'd3932, 16'd20493, 16'd21561},
      '{16'd46399, 16'd19137, 16'd11141, 16'd52232, 16'd8585, 16'd3015, 16'd20493, 16'd21561},
      '{16'd44564, 16'd20972, 16'd17367, 16'd45220, 16'd9830, 16'd3932, 16'd20578, 16'd23003},
      '{16'd41943, 16'd0, 16'd19661, 16'd39322, 16'd9830, 16'd3932, 16'd20493, 16'd21561},
      '{16'd60000, 16'd60000, 16'd50000, 16'd64000, 16'd40000, 16'd30000, 16'd52000, 16'd50000},
      '{16'd41943, 16'd21627, 16'd19661, 16'd39322, 16'd9830, 16'd3932, 16'd41943, 16'd21627},
      '{16'd41943, 16'd21627, 16'd19661, 16'd39322, 16'd9830, 16'd3932, 16'd9830, 16'd3932},
      '{16'd41943, 16'd21627, 16'd19661, 16'd39322, 16'd9830, 16'd3932, 16'd19661, 16'd39322},
      '{16'd41943, 16'd21627, 16'd19661, 16'd39322, 16'd9830, 16'd3932, 16'd9831, 16'd3933},
      '{16'd41943, 16'd0, 16'd19661, 16'd0, 16'd9830, 16'd0, 16'd20493, 16'd21561},
      '{16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'd21845, 16'd21845},
      '{16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC, 16'h5555, 16'h5555}
   };
   bit dir_degen [DIR_ROWS] = '{1, 1, 1, 0, 0, 0, 0, 0, 0, 1, 1, 0, 1, 0, 0};

   initial begin
      int phase_idle[4] = '{0, 79, 0, 31};
      int phase_stall[4] = '{0, 0, 79, 31};
      req_type r;
      rsp_type m;
      errors = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < DIR_ROWS; i++) begin
         r = req_type'({dir_rows[i][0], dir_rows[i][1], dir_rows[i][2], dir_rows[i][3],
                        dir_rows[i][4], dir_rows[i][5], dir_rows[i][6], dir_rows[i][7]});
         if (dir_degen[i]) begin
            m = '0;
            m.degenerate = 1'b1;
         end else begin
            m = predict_matrix(r);
         end
         send_word(r, m);
      end
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = phase_idle[p];
         recv_stall_pct = phase_stall[p];
         for (int i = 0; i < RAND_WORDS / 4; i++) begin
            r = random_set();
            send_word(r, predict_matrix(r));
         end
         // hold off until the pipeline has drained
         req_ch.valid <= 1'b0;
         wait_empty();
      end
      recv_stall_pct = 0;
      repeat (DRAIN_CYC) @(posedge clock);
      if (errors == 0 && matrix_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      logic signed [OUT_W-1:0] exp_f[11], act_f[11];
      string names[11] = '{"x_from_red", "x_from_green", "x_from_blue", "y_from_red",
                           "y_from_green", "y_from_blue", "z_from_red", "z_from_green",
                           "z_from_blue", "degenerate", "saturated"};
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (matrix_q.size() == 0) begin
            $display("%0t: unexpected word %h", $time, rsp_ch.data);
            errors++;
         end else begin
            want = matrix_q.pop_front();
            exp_f = '{want.x_from_red, want.x_from_green, want.x_from_blue,
                      want.y_from_red, want.y_from_green, want.y_from_blue,
                      want.z_from_red, want.z_from_green, want.z_from_blue,
                      OUT_W'(want.degenerate), OUT_W'(want.saturated)};
            act_f = '{rsp_ch.data.x_from_red, rsp_ch.data.x_from_green,
                      rsp_ch.data.x_from_blue, rsp_ch.data.y_from_red,
                      rsp_ch.data.y_from_green, rsp_ch.data.y_from_blue,
                      rsp_ch.data.z_from_red, rsp_ch.data.z_from_green,
                      rsp_ch.data.z_from_blue, OUT_W'(rsp_ch.data.degenerate),
                      OUT_W'(rsp_ch.data.saturated)};
            for (int k = 0; k < 11; k++) begin
               if (exp_f[k] !== act_f[k]) begin
                  $display("%0t: %s expected %0d actual %0d", $time, names[k],
                           exp_f[k], act_f[k]);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      #3000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
